### rtl/core/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the sorted insert table
// Transfer structs, status and action codes, and default sizes.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 6;
	localparam int COUNT_OUT_W  = 7;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		action_t                    action;
		logic signed [VALUE_W-1:0]  value;
		logic        [POS_W-1:0]    position;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]   read_value;
		status_t                     status;
		logic        [COUNT_OUT_W-1:0] entry_count;
	} result_t;

endpackage

### rtl/core/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sit_seq.sv
// ----------------------------------------------------------------------------
// sit_seq: sequencer of the sorted insert table
// Walks the stored entries from the top down, moving each one that is
// greater than the new value up by one place, then drops the value in.
// ----------------------------------------------------------------------------
module sit_seq import sit_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	output logic               done,
	output result_t            result,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [VALUE_W-1:0] mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  logic [VALUE_W-1:0] mem_rdata
);

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_INS  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_RD   = 4'b1000
	} state_t;

	state_t                    state_q, state_d;
	logic [AW-1:0]             k_q, k_d;
	logic [CW-1:0]             count_q, count_d;
	logic signed [VALUE_W-1:0] val_q, val_d;
	logic                      done_q, done_d;
	result_t                   result_q, result_d;
	logic                      full;
	logic                      pos_ok;
	logic                      gt;
	logic [CW-1:0]             count_inc;

	assign full      = (count_q == CW'(CAPACITY));
	assign pos_ok    = (CMPW'(cmd.position) < CMPW'(count_q)) &&
	                   (CMPW'(cmd.position) < CMPW'(CAPACITY));
	assign gt        = ($signed(mem_rdata) > val_q);
	assign count_inc = count_q + CW'(1);

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		count_d   = count_q;
		val_d     = val_q;
		done_d    = 1'b0;
		result_d  = result_q;
		mem_we    = 1'b0;
		mem_waddr = k_q;
		mem_wdata = val_q;
		mem_raddr = k_q - AW'(2);
		case (state_q)
			ST_IDLE: begin
				mem_raddr = (cmd.action == ACT_READ) ? AW'(cmd.position)
				                                     : AW'(count_q - CW'(1));
				if (start) begin
					val_d = cmd.value;
					if (cmd.action == ACT_INSERT) begin
						if (full) begin
							done_d               = 1'b1;
							result_d.read_value  = '0;
							result_d.status      = STATUS_FULL;
							result_d.entry_count = COUNT_OUT_W'(count_q);
						end else if (count_q == '0) begin
							mem_we               = 1'b1;
							mem_waddr            = '0;
							mem_wdata            = cmd.value;
							count_d              = count_inc;
							done_d               = 1'b1;
							result_d.read_value  = '0;
							result_d.status      = STATUS_OK;
							result_d.entry_count = COUNT_OUT_W'(count_inc);
						end else begin
							k_d     = AW'(count_q);
							state_d = ST_INS;
						end
					end else if (pos_ok) begin
						state_d = ST_RD;
					end else begin
						done_d               = 1'b1;
						result_d.read_value  = '0;
						result_d.status      = STATUS_RANGE;
						result_d.entry_count = COUNT_OUT_W'(count_q);
					end
				end
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = k_q;
				if (gt) begin
					mem_wdata = mem_rdata;
					k_d       = k_q - AW'(1);
					if (k_q == AW'(1)) begin
						state_d = ST_FIN;
					end
				end else begin
					mem_wdata            = val_q;
					count_d              = count_inc;
					done_d               = 1'b1;
					result_d.read_value  = '0;
					result_d.status      = STATUS_OK;
					result_d.entry_count = COUNT_OUT_W'(count_inc);
					state_d              = ST_IDLE;
				end
			end
			ST_FIN: begin
				mem_we               = 1'b1;
				mem_waddr            = '0;
				mem_wdata            = val_q;
				count_d              = count_inc;
				done_d               = 1'b1;
				result_d.read_value  = '0;
				result_d.status      = STATUS_OK;
				result_d.entry_count = COUNT_OUT_W'(count_inc);
				state_d              = ST_IDLE;
			end
			ST_RD: begin
				done_d               = 1'b1;
				result_d.read_value  = mem_rdata;
				result_d.status      = STATUS_OK;
				result_d.entry_count = COUNT_OUT_W'(count_q);
				state_d              = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q      <= k_d;
		val_q    <= val_d;
		result_q <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_count_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done_q)
		else $error("stored count changed without a result");

	a_shift_slot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> k_q != '0)
		else $error("shift walked below the bottom slot");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> done_q && state_q == ST_IDLE)
		else $error("final write did not produce a result");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> done_q && result_q.status == STATUS_OK)
		else $error("read did not return its entry");

endmodule

### rtl/core/sorted_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_insert_table: ascending table of signed 32-bit values
// Inserts keep equal values in arrival order; reads return one position.
//
//   channel   handshake             payload
//   command   start, busy           cmd    (action, value, position)
//   result    done (one cycle)      result (read_value, status, entry_count)
//
// A command transfers when start is high and busy is low.
// A read passes through the read state before its result; a dropped
// insert, an out-of-range read and an insert into an empty table are
// answered straight from idle. Any other insert moves each stored entry
// greater than the value up one place, in a one-entry-per-cycle walk
// through the table memory's single read and write port.
// The result is shown in the cycle after the item's last memory write.
// Reset clears the count; the table memory is not cleared. The receiver
// cannot stall, so done is never held off.
// ----------------------------------------------------------------------------
module sorted_insert_table import sit_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int AW = $clog2(CAPACITY);

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;

	sit_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sit_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule
